@@ hw/rtl/cpbl_pkg.sv @@
`default_nettype none

package cpbl_pkg;

    // fixed widths of the channel
    localparam int ADC_BITS   = 10;
    localparam int TERM_LIMIT = 55200;
    localparam int DUTY_MAX   = 3450;

    localparam int GAIN_W   = 12;
    localparam int TERM_W   = 17;
    localparam int PROD_W   = 30;
    localparam int VREF_W   = 16;
    localparam int CREF_W   = 12;
    localparam int DUTY_W   = 12;
    localparam int TGT_W    = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        OP_RESTART = 2'd0,
        OP_VSAMPLE = 2'd1,
        OP_ISAMPLE = 2'd2,
        OP_RAMP    = 2'd3
    } opcode_t;

    localparam logic [CFG_IDX_W-1:0] CFG_V_PROP_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_V_INT_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_I_PROP_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_OFFSET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_TARGET = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_START     = 3'd6;

    // input payload, last field in the lowest bits
    typedef struct packed {
        logic [1:0]          pad;
        logic [ADC_BITS-1:0] dclink_sample;
        logic [ADC_BITS-1:0] current_sample;
        logic [ADC_BITS-1:0] voltage_sample;
    } in_data_t;

    // result payload, last field in the lowest bits
    typedef struct packed {
        logic [6:0]               pad;
        logic                     ramp_done;
        logic signed [VREF_W-1:0] voltage_command;
        logic signed [CREF_W-1:0] current_command;
        logic [DUTY_W-1:0]        duty;
    } out_data_t;

    localparam logic signed [PROD_W-1:0] TermHi = PROD_W'(TERM_LIMIT);
    localparam logic signed [PROD_W-1:0] TermLo = -TermHi;

    function automatic logic signed [TERM_W-1:0] clamp_term(
        input logic signed [PROD_W-1:0] x
    );
        logic signed [TERM_W-1:0] r;
        if (x >= TermHi) begin
            r = TERM_W'(TermHi);
        end else if (x <= TermLo) begin
            r = TERM_W'(TermLo);
        end else begin
            r = x[TERM_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cascaded_pi_buck_loop_unit.sv @@
`default_nettype none

// One channel of a cascaded voltage/current loop for a buck converter. Each
// transaction on the s_ side carries an opcode in s_tuser (restart, voltage
// sample, current sample, ramp tick) and the three converter readings in
// s_tdata; each produces exactly one result on the m_ side with the duty,
// the current and voltage references after that item, and the ramp-done
// flag. An item is held in the input register, where the whole
// update is computed from the loop state, and then waits in the result
// register; the loop state is written in the same cycle, so a new item is
// taken every clock while m_tready stays high. Gains, offsets, target and
// ramp start are written through cfg_* (index as listed: v_prop_gain,
// v_int_gain, i_prop_gain, voltage_offset, current_offset, voltage_target,
// ramp_start); the user must write them only while no item is in flight,
// which the block does not enforce, and indexes beyond the list are ignored.
module cascaded_pi_buck_loop_unit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // voltage_sample, current_sample, dclink_sample, 2 bit pad
    input  wire logic [31:0]                        s_tdata,
    // opcode
    input  wire logic [1:0]                         s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // duty, current_command, voltage_command, ramp_done, 7 bit pad
    output logic [47:0]                             m_tdata,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [cpbl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [cpbl_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // configuration
    logic [cpbl_pkg::GAIN_W-1:0]            vkp_reg;
    logic [cpbl_pkg::GAIN_W-1:0]            vki_reg;
    logic [cpbl_pkg::GAIN_W-1:0]            ikp_reg;
    logic [cpbl_pkg::ADC_BITS-1:0]          voff_reg;
    logic [cpbl_pkg::ADC_BITS-1:0]          coff_reg;
    logic [cpbl_pkg::TGT_W-1:0]             target_reg;
    logic signed [cpbl_pkg::VREF_W-1:0]     ramp_start_reg;

    // loop state
    logic signed [cpbl_pkg::VREF_W-1:0]     vref_reg, vref_next;
    logic signed [cpbl_pkg::TERM_W-1:0]     integ_reg, integ_next;
    logic signed [cpbl_pkg::CREF_W-1:0]     cref_reg, cref_next;
    logic [cpbl_pkg::ADC_BITS-1:0]          prev_dc_reg, prev_dc_next;
    logic [cpbl_pkg::DUTY_W-1:0]            duty_reg, duty_next;

    // input and result stages
    logic                                   in_valid_reg;
    cpbl_pkg::opcode_t                      op_reg;
    cpbl_pkg::in_data_t                     in_reg;
    logic                                   out_valid_reg;
    cpbl_pkg::out_data_t                    out_reg, out_next;

    logic                                   fire;
    logic                                   out_free;
    logic                                   s_take;

    // datapath
    logic signed [11:0]                     vdiff;
    logic [10:0]                            vmeas;
    logic signed [16:0]                     verr;
    logic signed [cpbl_pkg::PROD_W-1:0]     vp_prod, vi_prod, cp_prod;
    logic signed [17:0]                     integ_sum;
    logic signed [cpbl_pkg::TERM_W-1:0]     integ_new, vp, vi, vsum_cl, cp;
    logic signed [17:0]                     vsum;
    logic signed [10:0]                     cdiff;
    logic [10:0]                            cmeas;
    logic signed [12:0]                     cerr;
    logic signed [17:0]                     dbase;
    logic [cpbl_pkg::DUTY_W-1:0]            d0;
    logic signed [10:0]                     dc_delta;
    logic signed [14:0]                     d_ff, d_sel;
    logic [cpbl_pkg::DUTY_W-1:0]            d_clamped;
    logic signed [16:0]                     tgt_ext;
    logic signed [16:0]                     vref_inc;
    logic signed [cpbl_pkg::VREF_W-1:0]     vref_ramp;
    logic                                   done_now;

    assign out_free  = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign s_take    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    always_comb begin
        tgt_ext  = $signed({6'b0, target_reg});
        done_now = $signed({vref_reg[15], vref_reg}) >= tgt_ext;

        // outer voltage PI
        vdiff     = $signed({2'b0, in_reg.voltage_sample}) - $signed({2'b0, voff_reg})
                    - 12'sd2;
        vmeas     = vdiff[11] ? 11'd0 : {vdiff[9:0], 1'b0};
        verr      = $signed({vref_reg[15], vref_reg}) - $signed({6'b0, vmeas});
        vp_prod   = cpbl_pkg::PROD_W'(verr)
                    * cpbl_pkg::PROD_W'($signed({1'b0, vkp_reg}));
        vp        = cpbl_pkg::clamp_term(vp_prod);
        integ_sum = $signed({integ_reg[16], integ_reg}) + $signed({verr[16], verr});
        integ_new = cpbl_pkg::clamp_term(cpbl_pkg::PROD_W'(integ_sum));
        vi_prod   = cpbl_pkg::PROD_W'(integ_new)
                    * cpbl_pkg::PROD_W'($signed({1'b0, vki_reg}));
        vi        = cpbl_pkg::clamp_term(vi_prod);
        vsum      = $signed({vp[16], vp}) + $signed({vi[16], vi});
        vsum_cl   = cpbl_pkg::clamp_term(cpbl_pkg::PROD_W'(vsum));

        // inner current P with dc-link feedforward
        cdiff     = $signed({1'b0, in_reg.current_sample}) - $signed({1'b0, coff_reg});
        cmeas     = cdiff[10] ? 11'd0 : {cdiff[9:0], 1'b0};
        cerr      = $signed({cref_reg[11], cref_reg}) - $signed({2'b0, cmeas});
        cp_prod   = cpbl_pkg::PROD_W'(cerr)
                    * cpbl_pkg::PROD_W'($signed({1'b0, ikp_reg}));
        cp        = cpbl_pkg::clamp_term(cp_prod);
        // always non-negative after the offset
        dbase     = $signed({cp[16], cp}) + $signed(18'(cpbl_pkg::TERM_LIMIT));
        d0        = dbase[16:5];
        dc_delta  = $signed({1'b0, in_reg.dclink_sample}) - $signed({1'b0, prev_dc_reg});
        d_ff      = $signed({3'b0, d0}) - $signed({dc_delta[10], dc_delta, 3'b0});
        d_sel     = done_now ? d_ff : $signed({3'b0, d0});
        if (d_sel < 15'sd0) begin
            d_clamped = '0;
        end else if (d_sel > $signed(15'(cpbl_pkg::DUTY_MAX))) begin
            d_clamped = cpbl_pkg::DUTY_W'(cpbl_pkg::DUTY_MAX);
        end else begin
            d_clamped = d_sel[cpbl_pkg::DUTY_W-1:0];
        end

        // soft start step, saturates at the target
        vref_inc  = $signed({vref_reg[15], vref_reg}) + 17'sd1;
        vref_ramp = (vref_inc >= tgt_ext) ? $signed({5'b0, target_reg})
                                          : vref_inc[15:0];

        vref_next    = vref_reg;
        integ_next   = integ_reg;
        cref_next    = cref_reg;
        prev_dc_next = prev_dc_reg;
        duty_next    = duty_reg;
        unique case (op_reg)
            cpbl_pkg::OP_RESTART: begin
                vref_next    = ramp_start_reg;
                integ_next   = '0;
                cref_next    = '0;
                duty_next    = '0;
                prev_dc_next = in_reg.dclink_sample;
            end
            cpbl_pkg::OP_VSAMPLE: begin
                integ_next = integ_new;
                cref_next  = vsum_cl[16:5];
            end
            cpbl_pkg::OP_ISAMPLE: begin
                duty_next    = d_clamped;
                prev_dc_next = in_reg.dclink_sample;
            end
            cpbl_pkg::OP_RAMP: begin
                vref_next = vref_ramp;
            end
            default: begin
                vref_next = vref_reg;
            end
        endcase

        out_next                 = '0;
        out_next.duty            = duty_next;
        out_next.current_command = cref_next;
        out_next.voltage_command = vref_next;
        out_next.ramp_done       = $signed({vref_next[15], vref_next}) >= tgt_ext;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vkp_reg        <= cpbl_pkg::GAIN_W'(1);
            vki_reg        <= cpbl_pkg::GAIN_W'(1);
            ikp_reg        <= cpbl_pkg::GAIN_W'(1);
            voff_reg       <= cpbl_pkg::ADC_BITS'(512);
            coff_reg       <= cpbl_pkg::ADC_BITS'(512);
            target_reg     <= '0;
            ramp_start_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                cpbl_pkg::CFG_V_PROP_GAIN:    vkp_reg <= cfg_data[cpbl_pkg::GAIN_W-1:0];
                cpbl_pkg::CFG_V_INT_GAIN:     vki_reg <= cfg_data[cpbl_pkg::GAIN_W-1:0];
                cpbl_pkg::CFG_I_PROP_GAIN:    ikp_reg <= cfg_data[cpbl_pkg::GAIN_W-1:0];
                cpbl_pkg::CFG_VOLTAGE_OFFSET: voff_reg <= cfg_data[cpbl_pkg::ADC_BITS-1:0];
                cpbl_pkg::CFG_CURRENT_OFFSET: coff_reg <= cfg_data[cpbl_pkg::ADC_BITS-1:0];
                cpbl_pkg::CFG_VOLTAGE_TARGET: target_reg <= cfg_data[cpbl_pkg::TGT_W-1:0];
                cpbl_pkg::CFG_RAMP_START:     ramp_start_reg <= $signed(cfg_data);
                default: begin
                    ramp_start_reg <= ramp_start_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vref_reg    <= '0;
            integ_reg   <= '0;
            cref_reg    <= '0;
            prev_dc_reg <= '0;
            duty_reg    <= '0;
        end else if (fire) begin
            vref_reg    <= vref_next;
            integ_reg   <= integ_next;
            cref_reg    <= cref_next;
            prev_dc_reg <= prev_dc_next;
            duty_reg    <= duty_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_take) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            op_reg <= cpbl_pkg::opcode_t'(s_tuser);
            in_reg <= cpbl_pkg::in_data_t'(s_tdata);
        end
        if (fire) begin
            out_reg <= out_next;
        end
    end

    // restart clears the loop state seen by the next item
    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && op_reg == cpbl_pkg::OP_RESTART)
        |=> (integ_reg == '0 && cref_reg == '0 && duty_reg == '0))
        else $error("restart did not clear loop state");

    a_integ_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (integ_reg <= $signed(cpbl_pkg::TERM_W'(cpbl_pkg::TERM_LIMIT)))
        && (integ_reg >= -$signed(cpbl_pkg::TERM_W'(cpbl_pkg::TERM_LIMIT))))
        else $error("integrator outside its limit");

    a_duty_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_reg.duty <= cpbl_pkg::DUTY_W'(cpbl_pkg::DUTY_MAX)))
        else $error("duty above maximum");

    a_result_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> (out_reg.voltage_command == vref_reg
                             && out_reg.duty == duty_reg
                             && out_reg.current_command == cref_reg))
        else $error("result does not match loop state");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without back pressure");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_PRINTED = 40;
    localparam logic [cpbl_pkg::CFG_IDX_W-1:0] CFG_NO_SUCH_REG = 3'd7;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [31:0] s_tdata;
    logic [1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [47:0] m_tdata;
    logic cfg_valid;
    logic cfg_ready;
    logic [cpbl_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [cpbl_pkg::CFG_DATA_W-1:0] cfg_data;

    cascaded_pi_buck_loop_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // loop settings as the block should hold them
    int kp_v = 1;
    int ki_v = 1;
    int kp_i = 1;
    int off_v = 512;
    int off_i = 512;
    int v_target = 0;
    int ramp_init = 0;

    // loop state
    int vref = 0;
    int integ = 0;
    int cref = 0;
    int dc_prev = 0;
    int duty_last = 0;

    cpbl_pkg::out_data_t loop_outputs_q[$];
    cpbl_pkg::out_data_t got_out;
    cpbl_pkg::out_data_t want_out;

    int mismatch_count = 0;
    int n_items = 0;
    int n_results = 0;
    int n_cfg_writes = 0;
    int op_seen [4] = '{0, 0, 0, 0};
    int cycle_count = 0;
    bit idle_on = 1'b1;
    int rx_hold_len = 0;

    function automatic longint limit_term(longint x);
        if (x >= cpbl_pkg::TERM_LIMIT) return cpbl_pkg::TERM_LIMIT;
        if (x <= -cpbl_pkg::TERM_LIMIT) return -cpbl_pkg::TERM_LIMIT;
        return x;
    endfunction

    function automatic cpbl_pkg::out_data_t step_loop(cpbl_pkg::opcode_t op,
                                                      logic [cpbl_pkg::ADC_BITS-1:0] vs,
                                                      logic [cpbl_pkg::ADC_BITS-1:0] cs,
                                                      logic [cpbl_pkg::ADC_BITS-1:0] dc);
        longint v, e, p, i, s, c, d;
        cpbl_pkg::out_data_t r;
        case (op)
            cpbl_pkg::OP_RESTART: begin
                vref = ramp_init;
                integ = 0;
                cref = 0;
                duty_last = 0;
                dc_prev = int'(dc);
            end
            cpbl_pkg::OP_VSAMPLE: begin
                v = (longint'(vs) - (longint'(off_v) + 2)) * 2;
                if (v < 0) v = 0;
                e = longint'(vref) - v;
                p = limit_term(e * longint'(kp_v));
                integ = int'(limit_term(longint'(integ) + e));
                i = limit_term(longint'(integ) * longint'(ki_v));
                s = limit_term(p + i);
                cref = int'(s >>> 5);
            end
            cpbl_pkg::OP_ISAMPLE: begin
                c = (longint'(cs) - longint'(off_i)) * 2;
                if (c < 0) c = 0;
                p = limit_term((longint'(cref) - c) * longint'(kp_i));
                d = (p + cpbl_pkg::TERM_LIMIT) >>> 5;
                // dc-link feedforward only once the soft start has finished
                if (vref >= v_target) d = d - (longint'(dc) - longint'(dc_prev)) * 8;
                if (d < 0) d = 0;
                if (d > cpbl_pkg::DUTY_MAX) d = cpbl_pkg::DUTY_MAX;
                duty_last = int'(d);
                dc_prev = int'(dc);
            end
            default: begin
                vref = vref + 1;
                if (vref >= v_target) vref = v_target;
            end
        endcase
        r = '0;
        r.duty = duty_last[cpbl_pkg::DUTY_W-1:0];
        r.current_command = cref[cpbl_pkg::CREF_W-1:0];
        r.voltage_command = vref[cpbl_pkg::VREF_W-1:0];
        r.ramp_done = (vref >= v_target);
        return r;
    endfunction

    function automatic void apply_reg(logic [cpbl_pkg::CFG_IDX_W-1:0] idx,
                                      logic [cpbl_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            cpbl_pkg::CFG_V_PROP_GAIN:    kp_v = int'(val[cpbl_pkg::GAIN_W-1:0]);
            cpbl_pkg::CFG_V_INT_GAIN:     ki_v = int'(val[cpbl_pkg::GAIN_W-1:0]);
            cpbl_pkg::CFG_I_PROP_GAIN:    kp_i = int'(val[cpbl_pkg::GAIN_W-1:0]);
            cpbl_pkg::CFG_VOLTAGE_OFFSET: off_v = int'(val[cpbl_pkg::ADC_BITS-1:0]);
            cpbl_pkg::CFG_CURRENT_OFFSET: off_i = int'(val[cpbl_pkg::ADC_BITS-1:0]);
            cpbl_pkg::CFG_VOLTAGE_TARGET: v_target = int'(val[cpbl_pkg::TGT_W-1:0]);
            cpbl_pkg::CFG_RAMP_START:     ramp_init = int'($signed(val));
            default: ;
        endcase
    endfunction

    function automatic logic [cpbl_pkg::ADC_BITS-1:0] near_code(int centre, int spread);
        int x;
        x = centre - spread + int'($urandom_range(0, 2 * spread));
        if (x < 0) x = 0;
        if (x > 1023) x = 1023;
        return x[cpbl_pkg::ADC_BITS-1:0];
    endfunction

    function automatic logic [cpbl_pkg::CFG_DATA_W-1:0] pick_gain();
        int unsigned sel;
        sel = $urandom_range(0, 5);
        case (sel)
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'd4095;
            3, 4: return 16'($urandom_range(1, 64));
            default: return 16'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic send_item(input cpbl_pkg::opcode_t op,
                             input logic [cpbl_pkg::ADC_BITS-1:0] vs,
                             input logic [cpbl_pkg::ADC_BITS-1:0] cs,
                             input logic [cpbl_pkg::ADC_BITS-1:0] dc);
        cpbl_pkg::in_data_t item;
        item = '0;
        item.voltage_sample = vs;
        item.current_sample = cs;
        item.dclink_sample = dc;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 99) < 16) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= item;
        do @(posedge aclk); while (!s_tready);
        loop_outputs_q.push_back(step_loop(op, vs, cs, dc));
        op_seen[op]++;
        n_items++;
    endtask

    task automatic send_random_item();
        send_item(cpbl_pkg::opcode_t'($urandom_range(0, 3)), 10'($urandom), 10'($urandom),
                  10'($urandom));
    endtask

    task automatic write_reg(input logic [cpbl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cpbl_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, val);
        n_cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // stop offering and wait until every predicted result has been seen
    task automatic wait_loop_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (loop_outputs_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic pick_loop_settings();
        int unsigned sel;
        write_reg(cpbl_pkg::CFG_V_PROP_GAIN, pick_gain());
        write_reg(cpbl_pkg::CFG_V_INT_GAIN, pick_gain());
        write_reg(cpbl_pkg::CFG_I_PROP_GAIN, pick_gain());
        write_reg(cpbl_pkg::CFG_VOLTAGE_OFFSET, ($urandom_range(0, 9) == 0) ?
                  16'($urandom_range(0, 1023)) : 16'($urandom_range(412, 612)));
        write_reg(cpbl_pkg::CFG_CURRENT_OFFSET, ($urandom_range(0, 9) == 0) ?
                  16'($urandom_range(0, 1023)) : 16'($urandom_range(412, 612)));
        write_reg(cpbl_pkg::CFG_VOLTAGE_TARGET, ($urandom_range(0, 9) == 0) ?
                  16'($urandom_range(0, 2046)) : 16'($urandom_range(0, 30)));
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            write_reg(cpbl_pkg::CFG_RAMP_START, 16'h8000);
        end else if (sel == 1) begin
            write_reg(cpbl_pkg::CFG_RAMP_START, 16'(-int'($urandom_range(0, 32768))));
        end else begin
            write_reg(cpbl_pkg::CFG_RAMP_START, 16'(-int'($urandom_range(0, 20))));
        end
    endtask

    task automatic test_reset_defaults();
        send_item(cpbl_pkg::OP_RESTART, 10'd0, 10'd0, 10'd0);
        send_item(cpbl_pkg::OP_RAMP, 10'd1023, 10'd1023, 10'd1023);
        send_item(cpbl_pkg::OP_VSAMPLE, 10'd0, 10'd0, 10'd0);
        send_item(cpbl_pkg::OP_VSAMPLE, 10'd1023, 10'd0, 10'd0);
        send_item(cpbl_pkg::OP_ISAMPLE, 10'd0, 10'd1023, 10'd1023);
        send_item(cpbl_pkg::OP_ISAMPLE, 10'd1023, 10'd0, 10'd0);
    endtask

    task automatic test_register_extremes();
        wait_loop_idle();
        write_reg(cpbl_pkg::CFG_V_PROP_GAIN, 16'd4095);
        write_reg(cpbl_pkg::CFG_V_INT_GAIN, 16'd4095);
        write_reg(cpbl_pkg::CFG_I_PROP_GAIN, 16'd4095);
        write_reg(cpbl_pkg::CFG_VOLTAGE_OFFSET, 16'd0);
        write_reg(cpbl_pkg::CFG_CURRENT_OFFSET, 16'd0);
        write_reg(cpbl_pkg::CFG_VOLTAGE_TARGET, 16'd2046);
        write_reg(cpbl_pkg::CFG_RAMP_START, 16'h8000);
        send_item(cpbl_pkg::OP_RESTART, 10'd0, 10'd0, 10'd1023);
        send_item(cpbl_pkg::OP_RAMP, 10'd0, 10'd0, 10'd0);
        send_item(cpbl_pkg::OP_VSAMPLE, 10'd1023, 10'd0, 10'd0);
        send_item(cpbl_pkg::OP_VSAMPLE, 10'd0, 10'd1023, 10'd1023);
        send_item(cpbl_pkg::OP_ISAMPLE, 10'd0, 10'd1023, 10'd0);
        send_item(cpbl_pkg::OP_ISAMPLE, 10'd0, 10'd0, 10'd1023);
        wait_loop_idle();
        // zero gains leave the duty at midscale, feedforward then swings it
        write_reg(cpbl_pkg::CFG_V_PROP_GAIN, 16'd0);
        write_reg(cpbl_pkg::CFG_V_INT_GAIN, 16'd0);
        write_reg(cpbl_pkg::CFG_I_PROP_GAIN, 16'd0);
        write_reg(cpbl_pkg::CFG_VOLTAGE_OFFSET, 16'd1023);
        write_reg(cpbl_pkg::CFG_CURRENT_OFFSET, 16'd1023);
        write_reg(cpbl_pkg::CFG_VOLTAGE_TARGET, 16'd0);
        write_reg(cpbl_pkg::CFG_RAMP_START, 16'd0);
        send_item(cpbl_pkg::OP_RESTART, 10'd0, 10'd0, 10'd0);
        send_item(cpbl_pkg::OP_ISAMPLE, 10'd0, 10'd1023, 10'd1023);
        send_item(cpbl_pkg::OP_ISAMPLE, 10'd0, 10'd0, 10'd0);
        send_item(cpbl_pkg::OP_VSAMPLE, 10'd1023, 10'd0, 10'd0);
    endtask

    task automatic test_reference_above_target();
        wait_loop_idle();
        // upper data bits beyond the register width are dropped
        write_reg(cpbl_pkg::CFG_V_PROP_GAIN, 16'hF00C);
        write_reg(cpbl_pkg::CFG_V_INT_GAIN, 16'd1);
        write_reg(cpbl_pkg::CFG_I_PROP_GAIN, 16'd1);
        write_reg(cpbl_pkg::CFG_VOLTAGE_TARGET, 16'd3);
        write_reg(CFG_NO_SUCH_REG, 16'hFFFF);
        send_item(cpbl_pkg::OP_RESTART, 10'd0, 10'd0, 10'd500);
        repeat (4) send_item(cpbl_pkg::OP_RAMP, 10'd0, 10'd0, 10'd0);
        wait_loop_idle();
        write_reg(cpbl_pkg::CFG_VOLTAGE_TARGET, 16'd1);
        send_item(cpbl_pkg::OP_VSAMPLE, 10'd600, 10'd0, 10'd0);
        send_item(cpbl_pkg::OP_RAMP, 10'd0, 10'd0, 10'd0);
    endtask

    // restart, ramp up, then paired voltage and current samples around the offsets
    task automatic test_soft_start_cycles();
        int k;
        while (n_items < 360) begin
            wait_loop_idle();
            pick_loop_settings();
            send_item(cpbl_pkg::OP_RESTART, 10'($urandom), 10'($urandom),
                      near_code(512, 200));
            k = v_target - ramp_init;
            if (k > 60) k = $urandom_range(0, 60);
            k = k + $urandom_range(0, 3);
            repeat (k) send_item(cpbl_pkg::OP_RAMP, 10'($urandom), 10'($urandom),
                                 10'($urandom));
            repeat ($urandom_range(4, 12)) begin
                send_item(cpbl_pkg::OP_VSAMPLE, near_code(off_v + 2, 40), 10'($urandom),
                          10'($urandom));
                send_item(cpbl_pkg::OP_ISAMPLE, 10'($urandom), near_code(off_i, 60),
                          near_code(dc_prev, 12));
                if ($urandom_range(0, 9) == 0) send_random_item();
                if ($urandom_range(0, 7) == 0) send_item(cpbl_pkg::OP_RAMP, 10'($urandom),
                                                         10'($urandom), 10'($urandom));
            end
        end
    endtask

    task automatic test_output_backpressure();
        wait_loop_idle();
        idle_on = 1'b0;
        rx_hold_len = 120;
        repeat (40) send_random_item();
        idle_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        repeat (20) send_item(cpbl_pkg::opcode_t'($urandom_range(0, 3)),
                              near_code(off_v + 2, 40), near_code(off_i, 60),
                              near_code(dc_prev, 20));
        wait_loop_idle();
        repeat (20) send_random_item();
    endtask

    task automatic test_random_opcodes();
        wait_loop_idle();
        pick_loop_settings();
        idle_on = 1'b0;
        repeat (40) send_random_item();
        idle_on = 1'b1;
        while (n_items < 500) send_random_item();
    endtask

    // result side: random stalls, plus a long hold when asked
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (rx_hold_len > 0) begin
                hold_left = rx_hold_len;
                rx_hold_len = 0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= !(idle_on && $urandom_range(0, 99) < 14);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            got_out = cpbl_pkg::out_data_t'(m_tdata);
            if (loop_outputs_q.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no item pending",
                                          n_results));
            end else begin
                want_out = loop_outputs_q.pop_front();
                if (got_out.duty !== want_out.duty)
                    report_mismatch($sformatf("result %0d duty: got %0d expected %0d",
                                              n_results, got_out.duty, want_out.duty));
                if (got_out.current_command !== want_out.current_command)
                    report_mismatch($sformatf("result %0d current_command: got %0d expected %0d",
                                              n_results, got_out.current_command,
                                              want_out.current_command));
                if (got_out.voltage_command !== want_out.voltage_command)
                    report_mismatch($sformatf("result %0d voltage_command: got %0d expected %0d",
                                              n_results, got_out.voltage_command,
                                              want_out.voltage_command));
                if (got_out.ramp_done !== want_out.ramp_done)
                    report_mismatch($sformatf("result %0d ramp_done: got %0b expected %0b",
                                              n_results, got_out.ramp_done,
                                              want_out.ramp_done));
            end
        end
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                 loop_outputs_q.size());
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = cpbl_pkg::OP_RESTART;
        cfg_valid = 1'b0;
        cfg_index = cpbl_pkg::CFG_V_PROP_GAIN;
        cfg_data = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_reference_above_target();
        test_soft_start_cycles();
        test_output_backpressure();
        test_sender_pause();
        test_random_opcodes();

        wait_loop_idle();
        repeat (8) @(posedge aclk);
        if (loop_outputs_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", loop_outputs_q.size()));
        $display("covered %0d items: %0d restart, %0d voltage, %0d current, %0d ramp tick",
                 n_items, op_seen[cpbl_pkg::OP_RESTART], op_seen[cpbl_pkg::OP_VSAMPLE],
                 op_seen[cpbl_pkg::OP_ISAMPLE], op_seen[cpbl_pkg::OP_RAMP]);
        $display("checked %0d results across %0d register writes, %0d mismatches",
                 n_results, n_cfg_writes, mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
